// File: src/cascade_pid_position_speed_macros.svh
// Assertion macros shared by the cascade PID position and speed controller.
`ifndef CASCADE_PID_POSITION_SPEED_MACROS_SVH
`define CASCADE_PID_POSITION_SPEED_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define CPPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a consequent holds in the cycle of its antecedent.
`define CPPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Checks that a consequent holds in the cycle after its antecedent.
`define CPPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPPS_ASSERT(lbl, prop, msg)
`define CPPS_ASSERT_IMP(lbl, ante, cons, msg)
`define CPPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/cpps_pkg.sv
// Types, constants and control codes of the cascade PID controller.
package cpps_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned ERR_W     = 18;
  localparam int unsigned OPND_W    = ERR_W + 1;
  localparam int unsigned PROD_W    = GAIN_W + 1 + OPND_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET   = 4'd0,
    REG_OUTER_KP = 4'd1,
    REG_OUTER_KI = 4'd2,
    REG_OUTER_KD = 4'd3,
    REG_INNER_KP = 4'd4,
    REG_INNER_KI = 4'd5,
    REG_INNER_KD = 4'd6,
    REG_LIMIT    = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_P = 2'd0,
    SEL_I = 2'd1,
    SEL_D = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic     err_en;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     rnd_en;
    logic     out_load;
    logic     inner;
  } ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] measured_position;
    logic [POS_W-1:0] measured_speed;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic signed [OUT_W-1:0] speed_target;
  } out_t;

endpackage

// File: src/cpps_mac.sv
// Shared multiply-accumulate unit with rounding and output saturation.
module cpps_mac
  import cpps_pkg::*;
(
  input  logic                     clk_i,
  input  ctrl_t                    ctrl_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic signed [OPND_W-1:0] opnd_i,
  output logic signed [OUT_W-1:0]  y_o
);

  logic signed [GAIN_W:0]    gain_s;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   rnd, shf;

  assign gain_s = $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= gain_s * opnd_i;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      default:  acc_d = acc_q;
    endcase
  end

  // Round to nearest with ties upward, then clip to the output range.
  assign rnd = acc_q + ROUND_HALF;
  assign shf = rnd >>> FRAC_BITS;

  always_comb begin
    priority if (shf > SAT_HI) begin
      y_o = SAT_HI[OUT_W-1:0];
    end else if (shf < SAT_LO) begin
      y_o = SAT_LO[OUT_W-1:0];
    end else begin
      y_o = shf[OUT_W-1:0];
    end
  end

endmodule

// File: src/cpps_ctrl.sv
// Sequencer that walks both loops through the shared multiply-accumulate unit.
module cpps_ctrl
  import cpps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_free_i,
  output logic  idle_o,
  output ctrl_t ctrl_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ERR  = 8'b0000_0010,
    ST_MP   = 8'b0000_0100,
    ST_MI   = 8'b0000_1000,
    ST_MD   = 8'b0001_0000,
    ST_AD   = 8'b0010_0000,
    ST_RND  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   inner_q, inner_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inner_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inner_q <= inner_d;
    end
  end

  always_comb begin
    state_d = state_q;
    inner_d = inner_q;
    ctrl_o  = '{err_en: 1'b0, mul_en: 1'b0, mul_sel: SEL_P, acc_op: ACC_HOLD,
                rnd_en: 1'b0, out_load: 1'b0, inner: inner_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          state_d = ST_ERR;
          inner_d = 1'b0;
        end
      end
      ST_ERR: begin
        ctrl_o.err_en = 1'b1;
        state_d = ST_MP;
      end
      ST_MP: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = SEL_P;
        state_d = ST_MI;
      end
      ST_MI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = SEL_I;
        ctrl_o.acc_op  = ACC_LOAD;
        state_d = ST_MD;
      end
      ST_MD: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = SEL_D;
        ctrl_o.acc_op  = ACC_ADD;
        state_d = ST_AD;
      end
      ST_AD: begin
        ctrl_o.acc_op = ACC_ADD;
        state_d = ST_RND;
      end
      ST_RND: begin
        ctrl_o.rnd_en = 1'b1;
        if (inner_q) begin
          state_d = ST_OUT;
        end else begin
          inner_d = 1'b1;
          state_d = ST_ERR;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

// File: src/cascade_pid_position_speed.sv
// Top level of the two-stage cascade PID controller for position and speed.
// Each input beat carries a measured position and a measured speed and yields
// exactly one output beat with the motor drive and the speed target. The outer
// loop compares the position with target_position and its saturated result is,
// in the same beat, the setpoint of the inner speed loop, whose result is the
// drive. Gains are unsigned Q16.16; both error sums saturate at plus or minus
// integral_limit, and both results round to nearest and saturate to 16-bit
// signed. Once a beat is accepted, in_ready_o stays low until its result is
// loaded into the output register, as both loops share one 33 by 19 bit
// multiplier and its accumulator and each loop uses it for an error update,
// three products, a final add and rounding. The result waits in that register,
// so the next beat can be taken while it is still pending; the block only
// stalls at its last step if the previous result was not yet taken. Registers
// are written through cfg_we_i, cfg_addr_i and cfg_wdata_i with no wait state;
// the user must write them only while the block is idle, which the block
// itself does not enforce; writes to an index above 7 are ignored and data
// bits above a register's width are dropped.
`include "cascade_pid_position_speed_macros.svh"

module cascade_pid_position_speed
  import cpps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [GAIN_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  // Configuration registers.
  logic [POS_W-1:0]  target_q, limit_q;
  logic [GAIN_W-1:0] okp_q, oki_q, okd_q, ikp_q, iki_q, ikd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= POS_W'(4000);
      okp_q    <= GAIN_W'(6554);
      oki_q    <= GAIN_W'(66);
      okd_q    <= '0;
      ikp_q    <= GAIN_W'(6554);
      iki_q    <= GAIN_W'(66);
      ikd_q    <= GAIN_W'(655);
      limit_q  <= POS_W'(900);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TARGET:   target_q <= cfg_wdata_i[POS_W-1:0];
        REG_OUTER_KP: okp_q    <= cfg_wdata_i;
        REG_OUTER_KI: oki_q    <= cfg_wdata_i;
        REG_OUTER_KD: okd_q    <= cfg_wdata_i;
        REG_INNER_KP: ikp_q    <= cfg_wdata_i;
        REG_INNER_KI: iki_q    <= cfg_wdata_i;
        REG_INNER_KD: ikd_q    <= cfg_wdata_i;
        REG_LIMIT:    limit_q  <= cfg_wdata_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  ctrl_t ctrl;
  logic  idle, in_fire, out_free;
  logic  out_valid_q;

  assign in_ready_o = idle;
  assign in_fire    = in_valid_i && idle;
  assign out_free   = !out_valid_q || out_ready_i;

  cpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .idle_o     (idle),
    .ctrl_o     (ctrl)
  );

  // The accepted sample is held for the whole computation.
  logic [POS_W-1:0] pos_q, spd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= in_data_i.measured_position;
      spd_q <= in_data_i.measured_speed;
    end
  end

  // Loop state: last error, the one before it, and the saturated error sum.
  logic signed [ERR_W-1:0]  o_last_q, o_prev_q, o_sum_q;
  logic signed [ERR_W-1:0]  i_last_q, i_prev_q, i_sum_q;
  logic signed [OPND_W-1:0] d_q;
  logic signed [OUT_W-1:0]  st_q;

  logic signed [ERR_W-1:0]  cur_last, cur_prev, cur_sum;
  logic signed [OPND_W-1:0] set_s, meas_s, err_w, sum_w, d_w, lim_w, sum_sat;
  logic signed [ERR_W-1:0]  err_n, sum_n;

  assign cur_last = ctrl.inner ? i_last_q : o_last_q;
  assign cur_prev = ctrl.inner ? i_prev_q : o_prev_q;
  assign cur_sum  = ctrl.inner ? i_sum_q  : o_sum_q;

  // The inner setpoint is the saturated speed target of this same beat.
  assign set_s  = ctrl.inner ? OPND_W'(st_q) : $signed({3'b000, target_q});
  assign meas_s = $signed({3'b000, ctrl.inner ? spd_q : pos_q});
  assign err_w  = set_s - meas_s;
  assign sum_w  = OPND_W'(cur_sum) + err_w;
  assign d_w    = OPND_W'(cur_last) - OPND_W'(cur_prev);
  assign lim_w  = $signed({3'b000, limit_q});

  always_comb begin
    priority if (sum_w > lim_w) begin
      sum_sat = lim_w;
    end else if (sum_w < -lim_w) begin
      sum_sat = -lim_w;
    end else begin
      sum_sat = sum_w;
    end
  end

  assign err_n = err_w[ERR_W-1:0];
  assign sum_n = sum_sat[ERR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_last_q <= '0;
      o_prev_q <= '0;
      o_sum_q  <= '0;
      i_last_q <= '0;
      i_prev_q <= '0;
      i_sum_q  <= '0;
    end else if (ctrl.err_en) begin
      if (ctrl.inner) begin
        i_last_q <= err_n;
        i_prev_q <= i_last_q;
        i_sum_q  <= sum_n;
      end else begin
        o_last_q <= err_n;
        o_prev_q <= o_last_q;
        o_sum_q  <= sum_n;
      end
    end
  end

  // The derivative uses the two errors stored before this update.
  always_ff @(posedge clk_i) begin
    if (ctrl.err_en) begin
      d_q <= d_w;
    end
  end

  // Operand and gain selection for the shared multiplier. After the update
  // the loop's last error and sum registers hold this beat's values.
  logic [GAIN_W-1:0]        gain;
  logic signed [OPND_W-1:0] opnd;
  logic signed [OUT_W-1:0]  y;

  always_comb begin
    unique case (ctrl.mul_sel)
      SEL_P: begin
        gain = ctrl.inner ? ikp_q : okp_q;
        opnd = OPND_W'(cur_last);
      end
      SEL_I: begin
        gain = ctrl.inner ? iki_q : oki_q;
        opnd = OPND_W'(cur_sum);
      end
      SEL_D: begin
        gain = ctrl.inner ? ikd_q : okd_q;
        opnd = d_q;
      end
      default: begin
        gain = '0;
        opnd = '0;
      end
    endcase
  end

  cpps_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .gain_i (gain),
    .opnd_i (opnd),
    .y_o    (y)
  );

  // The outer result is kept as the speed target; the inner result stays on
  // the accumulator output until it is loaded into the output register.
  always_ff @(posedge clk_i) begin
    if (ctrl.rnd_en && !ctrl.inner) begin
      st_q <= y;
    end
  end

  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_q.drive        <= y;
      out_q.speed_target <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CPPS_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready_o, "ready after accepted beat")
  `CPPS_ASSERT_IMP(a_no_overwrite, ctrl.out_load, out_free, "pending result overwritten")
  `CPPS_ASSERT_NXT(a_load_valid, ctrl.out_load, out_valid_q, "loaded result not valid")
  `CPPS_ASSERT(a_err_only_busy, !(ctrl.err_en && idle), "loop update while idle")

endmodule
